/* design/rbd_pkg.sv */
// Shared constants and types for the raster box downsampler.
package rbd_pkg;

  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 1;
  localparam int PIX_W     = 3 * CH_W;
  localparam int STORE_W   = 3 * SUM_W;
  localparam int DIM_W     = 13;
  localparam int ROW_W     = 12;
  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_HPAIR   = 2'd1;
  localparam logic [1:0] MODE_VPAIR   = 2'd2;
  localparam logic [1:0] MODE_BOX_ALT = 2'd3;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COMPONENTS = 2'd3;

  localparam logic [1:0] COMP_ONE = 2'd1;

  typedef struct packed {
    logic             use_store;
    logic             quarter;
    logic             last;
    logic [SUM_W-1:0] a2;
    logic [SUM_W-1:0] a1;
    logic [SUM_W-1:0] a0;
  } stage_t;

endpackage

/* design/rbd_ram.sv */
// Generic simple dual-port RAM with registered read.
module rbd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/raster_box_downsampler.sv */
// Raster box downsampler top level: 2x2, horizontal or vertical halving.
//
// Usage: source pixels enter on s_* in raster order, one transaction per
// pixel (c0 in the low byte). Halved pixels leave on m_*; m_tlast marks the
// last output pixel of the frame. Registers are written through cfg_we,
// cfg_index, cfg_data while the block is idle; any register write restarts
// the frame at column 0, row 0.
// Throughput: one source pixel per cycle unless the output stalls (see Stall).
// Each pixel makes at most one line-store access (write on an even row, read on
// an odd row); the write and read ports share one address.
// Pipeline: the source pixel that completes an output is registered into the
// read stage together with its line-store read, then into the output register
// that drives m_tvalid.
// Reset: registers go to box mode, 4096 x 4096, three channels; the position
// restarts at zero. The line store is not cleared; within a frame every entry
// is written before it is read.
// Stall: a two-deep buffer (read stage and output register) holds results;
// s_tready drops only when both hold a result and m_tready is low.
module raster_box_downsampler
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // pix_c0, pix_c1, pix_c2
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  m_tdata,   // out_c0, out_c1, out_c2
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > DIM_W) ? WW : DIM_W;

  logic [1:0]       mode;
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [1:0]       components;

  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] held_pixel;

  logic [EW-1:0]    sw_ext;
  logic [EW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [CW-1:0]    w_m1;
  logic [CW-1:0]    w_m2;
  logic [ROW_W-1:0] h_m1;
  logic [ROW_W-1:0] h_m2;
  logic             w_odd;
  logic             h_odd;
  logic [1:0]       mode_eff;

  logic             accept;
  logic [CH_W-1:0]  p0, p1, p2;
  logic [CH_W-1:0]  h0, h1, h2;
  logic [SUM_W-1:0] s0, s1, s2;
  logic             col_in, row_in, col_end, row_end, col_end_pair, row_end_pair;
  logic             hold_we;
  logic             emit;
  logic             ram_we;
  logic             ram_re;
  logic [CW-1:0]    ram_addr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;
  stage_t           stage_new;

  stage_t           st;
  logic             st_valid;
  logic             out_free;
  logic             st_adv;
  logic [CH_W-1:0]  r0, r1, r2;

  logic             out_valid;
  logic [PIX_W-1:0] out_data;
  logic             out_last;

  // effective frame size
  always_comb begin
    sw_ext = EW'(src_width);
    if (sw_ext == '0) begin
      w_eff = EW'(1);
    end else if (sw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = sw_ext;
    end
    if (src_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (src_height > DIM_W'(HEIGHT_LIMIT)) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = src_height;
    end
  end

  assign w_m1     = CW'(w_eff - EW'(1));
  assign w_m2     = CW'(w_eff - EW'(2));
  assign h_m1     = ROW_W'(h_eff - DIM_W'(1));
  assign h_m2     = ROW_W'(h_eff - DIM_W'(2));
  assign w_odd    = w_eff[0];
  assign h_odd    = h_eff[0];
  assign mode_eff = (mode == MODE_BOX_ALT) ? MODE_BOX : mode;

  assign accept = s_tvalid && s_tready;

  assign p0 = s_tdata[CH_W-1:0];
  assign p1 = (components == COMP_ONE) ? '0 : s_tdata[2*CH_W-1:CH_W];
  assign p2 = (components == COMP_ONE) ? '0 : s_tdata[3*CH_W-1:2*CH_W];
  assign h0 = held_pixel[CH_W-1:0];
  assign h1 = held_pixel[2*CH_W-1:CH_W];
  assign h2 = held_pixel[3*CH_W-1:2*CH_W];
  assign s0 = SUM_W'(h0) + SUM_W'(p0);
  assign s1 = SUM_W'(h1) + SUM_W'(p1);
  assign s2 = SUM_W'(h2) + SUM_W'(p2);

  assign col_end      = (col == w_m1);
  assign row_end      = (row == h_m1);
  assign col_in       = !(w_odd && col_end);
  assign row_in       = !(h_odd && row_end);
  assign col_end_pair = w_odd ? (col == w_m2) : col_end;
  assign row_end_pair = h_odd ? (row == h_m2) : row_end;

  // per-pixel action decode
  always_comb begin
    hold_we   = 1'b0;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = {s2, s1, s0};
    ram_addr  = col >> 1;
    stage_new = '{use_store: 1'b1, quarter: 1'b1, last: 1'b0,
                  a2: s2, a1: s1, a0: s0};
    case (mode_eff)
      MODE_BOX: begin
        if (col_in && row_in) begin
          if (!col[0]) begin
            hold_we = 1'b1;
          end else if (!row[0]) begin
            ram_we = 1'b1;
          end else begin
            ram_re         = 1'b1;
            emit           = 1'b1;
            stage_new.last = col_end_pair && row_end_pair;
          end
        end
      end
      MODE_HPAIR: begin
        stage_new.use_store = 1'b0;
        stage_new.quarter   = 1'b0;
        if (col_in) begin
          if (!col[0]) begin
            hold_we = 1'b1;
          end else begin
            emit           = 1'b1;
            stage_new.last = col_end_pair && row_end;
          end
        end
      end
      MODE_VPAIR: begin
        ram_addr          = col;
        ram_wdata         = {SUM_W'(p2), SUM_W'(p1), SUM_W'(p0)};
        stage_new.quarter = 1'b0;
        stage_new.a0      = SUM_W'(p0);
        stage_new.a1      = SUM_W'(p1);
        stage_new.a2      = SUM_W'(p2);
        if (row_in) begin
          if (!row[0]) begin
            ram_we = 1'b1;
          end else begin
            ram_re         = 1'b1;
            emit           = 1'b1;
            stage_new.last = col_end && row_end_pair;
          end
        end
      end
      default: begin
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (accept && ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // read stage: average the stage sums, adding line store data when use_store is set
  function automatic logic [CH_W-1:0] avg(input logic [SUM_W-1:0] a,
                                          input logic [SUM_W-1:0] b,
                                          input logic quarter);
    logic [SUM_W:0] total;
    total = {1'b0, a} + {1'b0, b} + (quarter ? (SUM_W+1)'(2) : (SUM_W+1)'(1));
    return quarter ? total[SUM_W:2] : total[SUM_W-1:1];
  endfunction

  always_comb begin
    if (st.use_store) begin
      r0 = avg(st.a0, ram_rdata[SUM_W-1:0], st.quarter);
      r1 = avg(st.a1, ram_rdata[2*SUM_W-1:SUM_W], st.quarter);
      r2 = avg(st.a2, ram_rdata[3*SUM_W-1:2*SUM_W], st.quarter);
    end else begin
      r0 = avg(st.a0, '0, st.quarter);
      r1 = avg(st.a1, '0, st.quarter);
      r2 = avg(st.a2, '0, st.quarter);
    end
  end

  assign out_free = !out_valid || m_tready;
  assign st_adv   = st_valid && out_free;
  assign s_tready = !st_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BOX;
      src_width  <= DIM_W'(4096);
      src_height <= DIM_W'(4096);
      components <= 2'd3;
      col        <= '0;
      row        <= '0;
      held_pixel <= '0;
      st_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:       mode       <= cfg_data[1:0];
          REG_SRC_WIDTH:  src_width  <= cfg_data;
          REG_SRC_HEIGHT: src_height <= cfg_data;
          REG_COMPONENTS: components <= cfg_data[1:0];
          default: begin
          end
        endcase
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (accept && hold_we) begin
        held_pixel <= {p2, p1, p0};
      end
      if (accept && emit) begin
        st_valid <= 1'b1;
      end else if (st_adv) begin
        st_valid <= 1'b0;
      end
      if (st_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      st <= stage_new;
    end
    if (st_adv) begin
      out_data <= {r2, r1, r0};
      out_last <= st.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= w_m1)
    else $error("column position beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= h_m1)
    else $error("row position beyond frame height");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(ram_we && ram_re))
    else $error("line store read and write for one pixel");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (st_valid && !st_adv && st.use_store) |=> $stable(ram_rdata))
    else $error("line store data changed under a stalled result");
`endif

endmodule
